>>> rtl/priority_task_queue_macros.svh
// Assertion helpers used by the queue datapath.
`ifndef PRIORITY_TASK_QUEUE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_MACROS_SVH

// Checked on every clock edge outside reset.
`define PTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/ptq_pkg.sv
`default_nettype none

package ptq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int PRI_W   = 8;
  localparam int HND_W   = 4;
  localparam int ARG_W   = 32;
  localparam int ENTRY_W = 5;
  localparam int STAT_W  = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Request kinds carried in the input tuser.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Read address selects.
  localparam logic [1:0] RD_HEAD   = 2'd0;
  localparam logic [1:0] RD_IDX_M1 = 2'd1;
  localparam logic [1:0] RD_IDX_M2 = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [HND_W-1:0] hnd;
    logic [ARG_W-1:0] arg;
  } slot_t;

  typedef struct packed {
    logic              load_req;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              wr_shift;
    logic              wr_new;
    logic              dec_idx;
    logic              pop;
    logic              finish;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic req_remove;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_one;
    logic prio_le;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/ptq_ctrl.sv
`default_nettype none

module ptq_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  ptq_pkg::sts_t  sts_i,
  output ptq_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [ptq_pkg::STAT_W-1:0] fin_st_q, fin_st_d;

  always_comb begin
    state_d    = state_q;
    fin_st_d   = fin_st_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.req_remove) begin
          if (sts_i.empty) begin
            fin_st_d = ptq_pkg::ST_EMPTY;
            state_d  = S_FIN;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = ptq_pkg::RD_HEAD;
            state_d      = S_REM;
          end
        end else if (sts_i.full) begin
          fin_st_d = ptq_pkg::ST_FULL;
          state_d  = S_FIN;
        end else if (sts_i.idx_zero) begin
          cmd_o.wr_new = 1'b1;
          fin_st_d     = ptq_pkg::ST_OK;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ptq_pkg::RD_IDX_M1;
          state_d      = S_INS;
        end
      end
      S_INS: begin
        if (sts_i.prio_le) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.dec_idx  = 1'b1;
          if (sts_i.idx_one) begin
            state_d = S_PUT;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = ptq_pkg::RD_IDX_M2;
          end
        end else begin
          cmd_o.wr_new = 1'b1;
          fin_st_d     = ptq_pkg::ST_OK;
          state_d      = S_FIN;
        end
      end
      S_PUT: begin
        cmd_o.wr_new = 1'b1;
        fin_st_d     = ptq_pkg::ST_OK;
        state_d      = S_FIN;
      end
      S_REM: begin
        cmd_o.pop = 1'b1;
        fin_st_d  = ptq_pkg::ST_OK;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = fin_st_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fin_st_q <= ptq_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      fin_st_q <= fin_st_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ptq_datapath.sv
`default_nettype none
`include "priority_task_queue_macros.svh"

module ptq_datapath #(
  parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ptq_pkg::cmd_t                cmd_i,
  output ptq_pkg::sts_t                sts_o,
  input  wire                          req_type_i,
  input  wire [ptq_pkg::PRI_W-1:0]     priority_req_i,
  input  wire [ptq_pkg::HND_W-1:0]     handler_id_i,
  input  wire [ptq_pkg::ARG_W-1:0]     argument_i,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [ptq_pkg::STAT_W-1:0]   status_o,
  output logic [ptq_pkg::PRI_W-1:0]    out_priority_o,
  output logic [ptq_pkg::HND_W-1:0]    out_handler_o,
  output logic [ptq_pkg::ARG_W-1:0]    out_argument_o,
  output logic [ptq_pkg::ENTRY_W-1:0]  entry_count_o
);

  localparam int LW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Map a position in queue order onto a slot of the circular store.
  function automatic logic [LW-1:0] phys(input logic [LW-1:0] head, input logic [LW-1:0] pos);
    logic [LW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (LW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (LW+1)'(QUEUE_DEPTH);
    end
    return sum[LW-1:0];
  endfunction

  ptq_pkg::slot_t mem [QUEUE_DEPTH];
  ptq_pkg::slot_t rdata_q;

  logic                        req_type_q;
  ptq_pkg::slot_t              req_q;
  ptq_pkg::slot_t              pop_q;
  logic [LW-1:0]               idx_q;
  logic [LW-1:0]               head_q;
  logic [CW-1:0]               count_q;
  logic                        out_valid_q;
  logic [ptq_pkg::STAT_W-1:0]  out_status_q;
  ptq_pkg::slot_t              out_slot_q;
  logic [CW-1:0]               out_count_q;

  logic [LW-1:0]   rd_pos;
  logic [LW-1:0]   rd_addr;
  logic [LW-1:0]   wr_addr;
  logic            wr_en;
  ptq_pkg::slot_t  wr_data;

  always_comb begin
    case (cmd_i.rd_sel)
      ptq_pkg::RD_IDX_M1: rd_pos = idx_q - LW'(1);
      ptq_pkg::RD_IDX_M2: rd_pos = idx_q - LW'(2);
      default:            rd_pos = '0;
    endcase
  end

  assign rd_addr = phys(head_q, rd_pos);
  assign wr_addr = phys(head_q, idx_q);
  assign wr_en   = cmd_i.wr_shift | cmd_i.wr_new;
  assign wr_data = cmd_i.wr_shift ? rdata_q : req_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Request, index, popped task and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      req_q      <= '{pri: priority_req_i, hnd: handler_id_i, arg: argument_i};
      idx_q      <= count_q[LW-1:0];
      pop_q      <= '0;
    end else begin
      if (cmd_i.dec_idx) begin
        idx_q <= idx_q - LW'(1);
      end
      if (cmd_i.pop) begin
        pop_q <= rdata_q;
      end
    end
    if (cmd_i.finish) begin
      out_status_q <= cmd_i.status;
      out_slot_q   <= pop_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_new) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CW'(1);
        head_q  <= phys(head_q, LW'(1));
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.req_remove = (req_type_q == ptq_pkg::REQ_REMOVE);
  assign sts_o.full       = (count_q >= CW'(QUEUE_DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.idx_one    = (idx_q == LW'(1));
  assign sts_o.prio_le    = (rdata_q.pri <= req_q.pri);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_priority_o = out_slot_q.pri;
  assign out_handler_o  = out_slot_q.hnd;
  assign out_argument_o = out_slot_q.arg;
  assign entry_count_o  = ptq_pkg::ENTRY_W'(out_count_q);

  `PTQ_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "task count beyond queue depth")
  `PTQ_ASSERT(a_no_grow_and_pop, !(cmd_i.wr_new && cmd_i.pop), "insert and pop in one cycle")
  `PTQ_ASSERT(a_finish_free, cmd_i.finish |-> (!out_valid_q || out_ready_i), "result overwritten")
  `PTQ_ASSERT(a_pop_count, cmd_i.pop |=> (count_q == $past(count_q) - CW'(1)), "pop lost count")

endmodule

`default_nettype wire

>>> rtl/priority_task_queue.sv
// An insert walks the slot memory from the tail towards the head, one slot per cycle,
// moving each stored task it passes up one slot, then writes the new task; one into an
// empty queue is written directly. A remove pops the head task, and a full insert or an
// empty remove returns only its status. One item is processed at a time, so the walk
// limits throughput. Reset clears the task count, head pointer and output valid.
`default_nettype none

module priority_task_queue #(
  parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input stream.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: priority_req[7:0], handler_id[11:8], argument[43:12], zero pad above.
  input  wire [ptq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: req_type[0].
  input  wire                                s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata: out_priority[7:0], out_handler[11:8], out_argument[43:12],
  // entry_count[48:44], zero pad above.
  output logic [ptq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: status[1:0].
  output logic [ptq_pkg::STAT_W-1:0]         m_axis_tuser
);

  localparam int PRI_LO = 0;
  localparam int HND_LO = PRI_LO + ptq_pkg::PRI_W;
  localparam int ARG_LO = HND_LO + ptq_pkg::HND_W;
  localparam int CNT_LO = ARG_LO + ptq_pkg::ARG_W;
  localparam int PAD_LO = CNT_LO + ptq_pkg::ENTRY_W;

  // The controller sequences each item; the datapath owns the slot memory,
  // the circular head pointer, the task count and the result register.
  ptq_pkg::cmd_t cmd;
  ptq_pkg::sts_t sts;

  logic [ptq_pkg::PRI_W-1:0]   out_priority;
  logic [ptq_pkg::HND_W-1:0]   out_handler;
  logic [ptq_pkg::ARG_W-1:0]   out_argument;
  logic [ptq_pkg::ENTRY_W-1:0] entry_count;

  ptq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (s_axis_tuser),
    .priority_req_i (s_axis_tdata[HND_LO-1:PRI_LO]),
    .handler_id_i   (s_axis_tdata[ARG_LO-1:HND_LO]),
    .argument_i     (s_axis_tdata[CNT_LO-1:ARG_LO]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .status_o       (m_axis_tuser),
    .out_priority_o (out_priority),
    .out_handler_o  (out_handler),
    .out_argument_o (out_argument),
    .entry_count_o  (entry_count)
  );

  // Pack the result fields, lowest field first, zeros up to the byte boundary.
  assign m_axis_tdata[HND_LO-1:PRI_LO]                   = out_priority;
  assign m_axis_tdata[ARG_LO-1:HND_LO]                   = out_handler;
  assign m_axis_tdata[CNT_LO-1:ARG_LO]                   = out_argument;
  assign m_axis_tdata[PAD_LO-1:CNT_LO]                   = entry_count;
  assign m_axis_tdata[ptq_pkg::OUT_TDATA_W-1:PAD_LO]     = '0;

endmodule

`default_nettype wire
